### hdl/midi_byte_parser_defines.svh
// Assertion macros for the MIDI byte parser.
// Define NO_ASSERTIONS to compile every check away to nothing.
`ifndef MIDI_BYTE_PARSER_DEFINES_SVH
`define MIDI_BYTE_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MBP_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("MIDI parser check failed: same-cycle implication");
`define MBP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("MIDI parser check failed: next-cycle implication");
`else
`define MBP_ASSERT_IMPLY(label, ante, cons)
`define MBP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hdl/mbp_pkg.sv
// Shared types and constants of the MIDI byte parser.
// No dependencies; mbp_front, mbp_cmd_fifo, mbp_back and midi_byte_parser import this package.
`timescale 1ns / 1ps
`default_nettype none

package mbp_pkg;

	typedef enum logic [3:0] {
		KIND_CLOCK     = 4'd0,
		KIND_START     = 4'd1,
		KIND_CONTINUE  = 4'd2,
		KIND_STOP      = 4'd3,
		KIND_NOTE_OFF  = 4'd4,
		KIND_NOTE_ON   = 4'd5,
		KIND_CTRL      = 4'd6,
		KIND_PROGRAM   = 4'd7,
		KIND_BEND      = 4'd8
	} kind_t;

	typedef enum logic [1:0] {
		CMD_REALTIME = 2'd0,
		CMD_STATUS   = 2'd1,
		CMD_DATA     = 2'd2
	} cmd_cls_t;

	typedef struct packed {
		cmd_cls_t   cls;
		kind_t      rt_kind;
		logic [7:0] value;
	} cmd_t;

	localparam logic [7:0] RT_FIRST    = 8'hF8;
	localparam logic [7:0] RT_CLOCK    = 8'hF8;
	localparam logic [7:0] RT_START    = 8'hFA;
	localparam logic [7:0] RT_CONTINUE = 8'hFB;
	localparam logic [7:0] RT_STOP     = 8'hFC;

	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_CTRL     = 4'hB;
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_BEND     = 4'hE;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

endpackage

`default_nettype wire

### hdl/mbp_in_if.sv
// Request channel carrying one received MIDI byte.
// Standalone interface; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mbp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hdl/mbp_out_if.sv
// Request channel carrying one decoded MIDI message.
// Standalone interface; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mbp_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         kind;
	logic [4:0]         chan;
	logic [6:0]         first_data;
	logic [6:0]         second_data;
	logic signed [13:0] bend_value;

	modport source (output valid, output kind, output chan, output first_data,
		output second_data, output bend_value, input ready);
	modport sink (input valid, input kind, input chan, input first_data,
		input second_data, input bend_value, output ready);
endinterface

`default_nettype wire

### hdl/mbp_front.sv
// Front end: accepts bytes and classifies them into queue commands.
// Depends on mbp_pkg and mbp_in_if.
`timescale 1ns / 1ps
`default_nettype none

module mbp_front import mbp_pkg::*; (
	mbp_in_if.sink     rx,
	output logic       push_valid,
	output cmd_t       push_cmd,
	input  logic       push_ready
);

	logic keep;

	always_comb begin
		push_cmd.cls     = CMD_DATA;
		push_cmd.rt_kind = KIND_CLOCK;
		push_cmd.value   = rx.rx_byte;
		keep             = 1'b1;
		if (rx.rx_byte >= RT_FIRST) begin
			push_cmd.cls = CMD_REALTIME;
			unique case (rx.rx_byte)
				RT_CLOCK:    push_cmd.rt_kind = KIND_CLOCK;
				RT_START:    push_cmd.rt_kind = KIND_START;
				RT_CONTINUE: push_cmd.rt_kind = KIND_CONTINUE;
				RT_STOP:     push_cmd.rt_kind = KIND_STOP;
				default:     keep = 1'b0;
			endcase
		end else if (rx.rx_byte[7]) begin
			push_cmd.cls = CMD_STATUS;
		end
	end

	// Undefined real-time bytes are taken and dropped here.
	assign rx.ready   = push_ready;
	assign push_valid = rx.valid && keep;

endmodule

`default_nettype wire

### hdl/mbp_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on mbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbp_cmd_fifo import mbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  cmd_t push_cmd,
	output logic push_ready,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop_ready
);

	cmd_t                  entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  push;
	logic                  pop;

	assign push_ready = (count_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

### hdl/mbp_back.sv
// Back end: holds running status and partial data, builds messages.
// Depends on mbp_pkg and mbp_out_if.
`timescale 1ns / 1ps
`default_nettype none

module mbp_back import mbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_ready,
	mbp_out_if.source   msg
);

	logic [7:0]         status_q;
	logic [6:0]         first_q;
	logic               bytes_q;
	logic               out_valid_q;
	kind_t              out_kind_q;
	logic [4:0]         out_chan_q;
	logic [6:0]         out_d1_q;
	logic [6:0]         out_d2_q;
	logic signed [13:0] out_bend_q;

	logic [7:0]         status_d;
	logic [6:0]         first_d;
	logic               bytes_d;
	logic               res_valid;
	kind_t              res_kind;
	logic [4:0]         res_chan;
	logic [6:0]         res_d1;
	logic [6:0]         res_d2;
	logic signed [13:0] res_bend;
	logic [4:0]         chan_calc;
	logic               pop;

	assign cmd_ready = !out_valid_q || msg.ready;
	assign pop       = cmd_valid && cmd_ready;
	assign chan_calc = {1'b0, status_q[3:0]} + 5'd1;

	always_comb begin
		status_d  = status_q;
		first_d   = first_q;
		bytes_d   = bytes_q;
		res_valid = 1'b0;
		res_kind  = KIND_CLOCK;
		res_chan  = 5'd1;
		res_d1    = '0;
		res_d2    = '0;
		res_bend  = '0;
		unique case (cmd.cls)
			CMD_REALTIME: begin
				res_valid = 1'b1;
				res_kind  = cmd.rt_kind;
			end
			CMD_STATUS: begin
				status_d = cmd.value;
				first_d  = '0;
				bytes_d  = 1'b0;
			end
			CMD_DATA: begin
				if (status_q != '0) begin
					res_chan = chan_calc;
					if (status_q[7:4] == NIB_PROGRAM) begin
						first_d   = '0;
						bytes_d   = 1'b0;
						res_valid = 1'b1;
						res_kind  = KIND_PROGRAM;
						res_d1    = cmd.value[6:0];
					end else if (!bytes_q) begin
						first_d = cmd.value[6:0];
						bytes_d = 1'b1;
					end else begin
						first_d = '0;
						bytes_d = 1'b0;
						unique case (status_q[7:4])
							NIB_NOTE_OFF: begin
								res_valid = 1'b1;
								res_kind  = KIND_NOTE_OFF;
								res_d1    = first_q;
								res_d2    = cmd.value[6:0];
							end
							NIB_NOTE_ON: begin
								res_valid = 1'b1;
								res_kind  = KIND_NOTE_ON;
								res_d1    = first_q;
								res_d2    = cmd.value[6:0];
							end
							NIB_CTRL: begin
								res_valid = 1'b1;
								res_kind  = KIND_CTRL;
								res_d1    = first_q;
								res_d2    = cmd.value[6:0];
							end
							NIB_BEND: begin
								// Subtracting the center flips the top bit of the 14-bit value.
								res_valid = 1'b1;
								res_kind  = KIND_BEND;
								res_bend  = signed'({~cmd.value[6], cmd.value[5:0], first_q});
							end
							default: begin
								res_valid = 1'b0;
							end
						endcase
					end
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= '0;
			first_q     <= '0;
			bytes_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				status_q <= status_d;
				first_q  <= first_d;
				bytes_q  <= bytes_d;
			end
			if (cmd_ready) begin
				out_valid_q <= pop && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			out_kind_q <= res_kind;
			out_chan_q <= res_chan;
			out_d1_q   <= res_d1;
			out_d2_q   <= res_d2;
			out_bend_q <= res_bend;
		end
	end

	assign msg.valid       = out_valid_q;
	assign msg.kind        = out_kind_q;
	assign msg.chan        = out_chan_q;
	assign msg.first_data  = out_d1_q;
	assign msg.second_data = out_d2_q;
	assign msg.bend_value  = out_bend_q;

endmodule

`default_nettype wire

### hdl/midi_byte_parser.sv
// MIDI byte parser with running status.
//
// Channel rx takes one received MIDI byte per request; channel msg returns
// one decoded message per request (kind, chan, first_data, second_data,
// bend_value). A request moves when valid and ready are both high.
// The front end classifies each byte and drops undefined real-time bytes;
// a two-entry command queue separates it from the back end, which holds the
// running status and any partial data byte and loads a registered output.
// Throughput is one byte per cycle while msg.ready stays high. A byte that
// produces a message is written into the command queue when it is taken;
// the back end pops it from the queue and loads the output register in the
// same cycle, once that register is free, and msg.valid then rises.
// Reset clears the running status, the partial data byte, the queue and the
// output valid flag; rx is ready as soon as reset is released.
// When the receiver stalls, the output register holds its message, the
// queue fills, and rx.ready drops once both queue entries are occupied.
// Depends on mbp_pkg, mbp_in_if, mbp_out_if, mbp_front, mbp_cmd_fifo, mbp_back.
`timescale 1ns / 1ps
`default_nettype none
`include "midi_byte_parser_defines.svh"

module midi_byte_parser import mbp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	mbp_in_if.sink     rx,
	mbp_out_if.source  msg
);

	logic push_valid;
	cmd_t push_cmd;
	logic push_ready;
	logic pop_valid;
	cmd_t pop_cmd;
	logic pop_ready;

	mbp_front u_front (
		.rx         (rx),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	mbp_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd),
		.pop_ready  (pop_ready)
	);

	mbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.cmd_ready (pop_ready),
		.msg       (msg)
	);

	`MBP_ASSERT_IMPLY(a_chan_range, msg.valid, (msg.chan >= 5'd1) && (msg.chan <= 5'd16))
	`MBP_ASSERT_IMPLY(a_bend_only, msg.valid && (msg.kind != KIND_BEND), msg.bend_value == 14'sd0)
	`MBP_ASSERT_NEXT(a_full_holds, !push_ready && !(pop_valid && pop_ready), !push_ready)

endmodule

`default_nettype wire

### test/midi_byte_parser_test.sv
// Testbench for midi_byte_parser: directed and random MIDI byte streams with random stalls.
// Predicts each decoded message from its own copy of the parser state and compares fields.
// Depends on mbp_pkg, mbp_in_if, mbp_out_if and midi_byte_parser.
`timescale 1ns / 1ps

module midi_byte_parser_test;
	import mbp_pkg::*;

	localparam logic [7:0] RT_UNDEF_F9 = 8'hF9;
	localparam logic [7:0] RT_UNDEF_FD = 8'hFD;
	localparam logic [7:0] RT_UNDEF_FE = 8'hFE;
	localparam logic [7:0] RT_UNDEF_FF = 8'hFF;
	localparam logic [3:0] NIB_POLY_TOUCH = 4'hA;
	localparam logic [3:0] NIB_CHAN_TOUCH = 4'hD;
	localparam logic [3:0] NIB_SYSTEM = 4'hF;
	localparam int BEND_CENTER = 8192;
	localparam int RANDOM_ITEMS = 1500;
	localparam int STEADY_ITEMS = 250;

	typedef struct packed {
		kind_t              kind;
		logic [4:0]         chan;
		logic [6:0]         first_data;
		logic [6:0]         second_data;
		logic signed [13:0] bend_value;
	} midi_msg_t;

	logic clk;
	logic arst_n;

	mbp_in_if rx_ch();
	mbp_out_if msg_ch();

	midi_byte_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.msg(msg_ch)
	);

	logic [7:0] running_status;
	logic [6:0] pending_first;
	logic       pending_valid;
	midi_msg_t  expected_msgs[$];
	int         error_count;
	int         bytes_sent;
	bit         rx_gaps_on;
	bit         msg_stalls_on;
	int         msg_stall_left;

	always #4 clk = ~clk;

	function automatic logic decode_byte(input logic [7:0] b, output midi_msg_t m);
		logic [6:0] d1;
		int bend_full;
		m = '0;
		m.chan = 5'd1;
		if (b >= RT_FIRST) begin
			case (b)
				RT_CLOCK: begin
					m.kind = KIND_CLOCK;
					return 1'b1;
				end
				RT_START: begin
					m.kind = KIND_START;
					return 1'b1;
				end
				RT_CONTINUE: begin
					m.kind = KIND_CONTINUE;
					return 1'b1;
				end
				RT_STOP: begin
					m.kind = KIND_STOP;
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		end
		if (b[7]) begin
			running_status = b;
			pending_valid = 1'b0;
			pending_first = '0;
			return 1'b0;
		end
		if (running_status == 8'h00)
			return 1'b0;
		m.chan = {1'b0, running_status[3:0]} + 5'd1;
		if (running_status[7:4] == NIB_PROGRAM) begin
			pending_valid = 1'b0;
			pending_first = '0;
			m.kind = KIND_PROGRAM;
			m.first_data = b[6:0];
			return 1'b1;
		end
		if (!pending_valid) begin
			pending_first = b[6:0];
			pending_valid = 1'b1;
			return 1'b0;
		end
		d1 = pending_first;
		pending_valid = 1'b0;
		pending_first = '0;
		case (running_status[7:4]) inside
			NIB_NOTE_OFF, NIB_NOTE_ON, NIB_CTRL: begin
				if (running_status[7:4] == NIB_NOTE_OFF)
					m.kind = KIND_NOTE_OFF;
				else if (running_status[7:4] == NIB_NOTE_ON)
					m.kind = KIND_NOTE_ON;
				else
					m.kind = KIND_CTRL;
				m.first_data = d1;
				m.second_data = b[6:0];
				return 1'b1;
			end
			NIB_BEND: begin
				bend_full = int'({b[6:0], d1}) - BEND_CENTER;
				m.kind = KIND_BEND;
				m.bend_value = bend_full[13:0];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b);
		midi_msg_t m;
		if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
			rx_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
		if (decode_byte(b, m))
			expected_msgs.insert(expected_msgs.size(), m);
	endtask

	task automatic send_data_bytes(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_byte(8'(RT_FIRST + $urandom_range(0, 7)));
			case ($urandom_range(0, 9))
				0: send_byte(8'h00);
				1: send_byte(8'h7F);
				default: send_byte(8'($urandom_range(0, 127)));
			endcase
		end
	endtask

	task automatic test_realtime_and_orphan_data();
		send_byte(8'h7F);
		send_byte(RT_CLOCK);
		send_byte(RT_START);
		send_byte(RT_CONTINUE);
		send_byte(RT_STOP);
		send_byte(RT_UNDEF_F9);
		send_byte(RT_UNDEF_FD);
		send_byte(RT_UNDEF_FE);
		send_byte(RT_UNDEF_FF);
	endtask

	task automatic test_channel_messages();
		send_byte({NIB_NOTE_OFF, 4'h0});
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte({NIB_NOTE_ON, 4'hF});
		send_byte(8'h7F);
		send_byte(8'h00);
		send_byte({NIB_CTRL, 4'h5});
		send_byte(8'h07);
		send_byte(RT_CLOCK);
		send_byte(8'h64);
		send_byte({NIB_PROGRAM, 4'h0});
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte({NIB_BEND, 4'h3});
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h7F);
		send_byte(8'h7F);
	endtask

	task automatic test_silent_statuses();
		send_byte({NIB_POLY_TOUCH, 4'h2});
		send_byte(8'h10);
		send_byte(8'h20);
		send_byte({NIB_SYSTEM, 4'h7});
		send_byte(8'h01);
		send_byte(8'h02);
	endtask

	task automatic send_random_sequence();
		logic [3:0] nib;
		int needed;
		case ($urandom_range(0, 99)) inside
			[0:5]: send_byte(8'(RT_FIRST + $urandom_range(0, 7)));
			[6:11]: send_byte(8'($urandom_range(0, 255)));
			default: begin
				if (running_status == 8'h00 || $urandom_range(0, 2) != 0) begin
					case ($urandom_range(0, 9)) inside
						0, 1: nib = NIB_NOTE_ON;
						2: nib = NIB_NOTE_OFF;
						3: nib = NIB_CTRL;
						4: nib = NIB_PROGRAM;
						5: nib = NIB_BEND;
						6: nib = NIB_POLY_TOUCH;
						7: nib = NIB_CHAN_TOUCH;
						8: nib = NIB_SYSTEM;
						default: nib = 4'($urandom_range(8, 15));
					endcase
					if (nib == NIB_SYSTEM)
						send_byte({nib, 1'b0, 3'($urandom_range(0, 7))});
					else
						send_byte({nib, 4'($urandom_range(0, 15))});
				end
				needed = (running_status[7:4] == NIB_PROGRAM) ? 1 : 2;
				if ($urandom_range(0, 9) == 0)
					needed = $urandom_range(0, 3);
				send_data_bytes(needed);
			end
		endcase
	endtask

	task automatic test_random_stream();
		int target;
		target = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < target)
			send_random_sequence();
	endtask

	task automatic test_steady_stream();
		int target;
		rx_gaps_on = 1'b0;
		msg_stalls_on = 1'b0;
		target = bytes_sent + STEADY_ITEMS;
		while (bytes_sent < target)
			send_random_sequence();
	endtask

	always @(posedge clk) begin : msg_checker
		midi_msg_t want;
		if (arst_n && msg_ch.valid && msg_ch.ready) begin
			if (expected_msgs.size() == 0) begin
				$error("unexpected message: kind %0d chan %0d", msg_ch.kind, msg_ch.chan);
				error_count++;
			end else begin
				want = expected_msgs.pop_front();
				if (msg_ch.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, msg_ch.kind);
					error_count++;
				end
				if (msg_ch.chan !== want.chan) begin
					$error("chan: expected %0d, got %0d", want.chan, msg_ch.chan);
					error_count++;
				end
				if (msg_ch.first_data !== want.first_data) begin
					$error("first_data: expected %0d, got %0d", want.first_data,
						msg_ch.first_data);
					error_count++;
				end
				if (msg_ch.second_data !== want.second_data) begin
					$error("second_data: expected %0d, got %0d", want.second_data,
						msg_ch.second_data);
					error_count++;
				end
				if (msg_ch.bend_value !== want.bend_value) begin
					$error("bend_value: expected %0d, got %0d", want.bend_value,
						msg_ch.bend_value);
					error_count++;
				end
			end
		end
		if (!msg_stalls_on) begin
			msg_ch.ready <= 1'b1;
		end else if (msg_stall_left > 0) begin
			msg_stall_left--;
			msg_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			msg_stall_left = $urandom_range(1, 19) - 1;
			msg_ch.ready <= 1'b0;
		end else begin
			msg_ch.ready <= 1'b1;
		end
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = 8'h00;
		msg_ch.ready = 1'b0;
		running_status = 8'h00;
		pending_first = '0;
		pending_valid = 1'b0;
		error_count = 0;
		bytes_sent = 0;
		rx_gaps_on = 1'b1;
		msg_stalls_on = 1'b1;
		msg_stall_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_realtime_and_orphan_data();
		test_channel_messages();
		test_silent_statuses();
		test_random_stream();
		test_steady_stream();

		rx_ch.valid <= 1'b0;
		while (expected_msgs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
